### rtl/pdc_pkg.sv
// Shared types, constants and helpers of the Poisson-disc candidate check.
// No dependencies; imported by the top level.
`default_nettype none

package pdc_pkg;

    // Grid and store geometry.
    localparam int GRID_COLS  = 32;
    localparam int GRID_ROWS  = 32;
    localparam int MAX_POINTS = 1024;
    localparam int CELLS      = GRID_COLS * GRID_ROWS;

    localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // Field widths of the stream words.
    localparam int COORD_W = 24;
    localparam int LEN_W   = 23;
    localparam int CIDX_W  = 6;
    localparam int SLOT_W  = 11;
    localparam int POINT_W = 2 * COORD_W;

    // Arithmetic widths: differences and edges at 25 bits, squares at 50.
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_X      = 3'd0,
        CFG_REGION_Y      = 3'd1,
        CFG_REGION_WIDTH  = 3'd2,
        CFG_REGION_HEIGHT = 3'd3,
        CFG_MIN_RADIUS    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_OUTSIDE   = 2'd1,
        VERDICT_TOO_CLOSE = 2'd2,
        VERDICT_FULL      = 2'd3
    } verdict_t;

    // Linear grid address of a cell, row major.
    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [CELL_W-1:0] base;
        base = CELL_W'(row) * CELL_W'(GRID_COLS);
        return base + CELL_W'(col);
    endfunction

endpackage

`default_nettype wire

### rtl/poisson_disc_candidate_check_unit.sv
// Top level of the Poisson-disc candidate check: sequencer, shared squaring
// unit, configuration registers. Depends on pdc_pkg and pdc_ram.
`default_nettype none

// The block checks one candidate point (signed Q16.8) against a rectangle and
// against the points already stored near it, and appends it when it passes.
// After reset the cell grid is swept to empty, one cell per clock, over all
// GRID_COLS*GRID_ROWS = 1024 cells; s_tready stays low during the sweep while
// configuration writes are still taken. One word is handled at a time: s_tready
// is high only while the sequencer waits for a new word. A candidate outside
// the rectangle skips the search; its result goes to the output register.
// Otherwise the clamped 5x5 block of cells around the candidate's cell is
// visited one cell after the other through the grid RAM and the point store
// RAM: an empty cell takes a grid read and a check of its entry, an occupied
// one also a store read, the difference, two squarings on the one shared
// 25x25 squarer, and the compare. At most 25 cells are visited, and a
// too-close point ends the search early. Results leave through an output
// register, so a new word is taken while the last result still waits.

module poisson_disc_candidate_check_unit
    import pdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Candidate words. s_tdata fields from bit 0 up: cand_x[23:0],
    // cand_y[23:0], cell_col[5:0], cell_row[5:0], 4 zero bits.
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [63:0]            s_tdata,
    // Result words. m_tdata fields from bit 0 up: verdict[1:0],
    // stored_index[10:0], point_count[10:0].
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [23:0]            m_tdata,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REGION,
        S_LIMIT,
        S_GRID,
        S_ENT,
        S_PT,
        S_SQX,
        S_SQY,
        S_CMP,
        S_CAP,
        S_DONE
    } state_t;

    // Configuration registers.
    logic signed [COORD_W-1:0] region_x_reg;
    logic signed [COORD_W-1:0] region_y_reg;
    logic [LEN_W-1:0]          region_width_reg;
    logic [LEN_W-1:0]          region_height_reg;
    logic [LEN_W-1:0]          min_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_x_reg      <= '0;
            region_y_reg      <= '0;
            region_width_reg  <= '0;
            region_height_reg <= '0;
            min_radius_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REGION_X:      region_x_reg      <= cfg_wdata;
                CFG_REGION_Y:      region_y_reg      <= cfg_wdata;
                CFG_REGION_WIDTH:  region_width_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_REGION_HEIGHT: region_height_reg <= cfg_wdata[LEN_W-1:0];
                CFG_MIN_RADIUS:    min_radius_reg    <= cfg_wdata[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sequencer state and datapath registers.
    state_t                    state_reg,   state_next;
    logic [CELL_W-1:0]         clr_reg,     clr_next;
    logic signed [COORD_W-1:0] cx_reg,      cx_next;
    logic signed [COORD_W-1:0] cy_reg,      cy_next;
    logic [COL_W-1:0]          col_reg,     col_next;     // candidate's cell
    logic [ROW_W-1:0]          row_reg,     row_next;
    logic [COL_W-1:0]          c0_reg,      c0_next;      // neighbourhood bounds
    logic [COL_W-1:0]          c1_reg,      c1_next;
    logic [ROW_W-1:0]          r1_reg,      r1_next;
    logic [COL_W-1:0]          ic_reg,      ic_next;      // cell being visited
    logic [ROW_W-1:0]          ir_reg,      ir_next;
    logic [DIFF_W-1:0]         adx_reg,     adx_next;
    logic [DIFF_W-1:0]         ady_reg,     ady_next;
    logic [SQ_W-1:0]           prod_reg,    prod_next;
    logic [SQ_W-1:0]           acc_reg,     acc_next;
    logic [SQ_W-1:0]           limit_reg,   limit_next;
    logic [SLOT_W-1:0]         total_reg,   total_next;
    logic [SLOT_W-1:0]         slot_reg,    slot_next;
    verdict_t                  verdict_reg, verdict_next;
    logic                      out_valid_reg, out_valid_next;
    logic [23:0]               out_data_reg,  out_data_next;

    // Memory ports.
    logic                      grid_we;
    logic [CELL_W-1:0]         grid_waddr;
    logic [SLOT_W-1:0]         grid_wdata;
    logic [SLOT_W-1:0]         grid_rdata;
    logic                      store_we;
    logic [PADDR_W-1:0]        store_raddr;
    logic [POINT_W-1:0]        store_rdata;

    pdc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (cell_addr(ir_reg, ic_reg)),
        .rdata (grid_rdata)
    );

    pdc_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (total_reg[PADDR_W-1:0]),
        .wdata ({cy_reg, cx_reg}),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Input word fields.
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic [CIDX_W-1:0]         in_col;
    logic [CIDX_W-1:0]         in_row;
    logic [CIDX_W-1:0]         col_clamp;
    logic [CIDX_W-1:0]         row_clamp;

    assign in_x   = s_tdata[23:0];
    assign in_y   = s_tdata[47:24];
    assign in_col = s_tdata[53:48];
    assign in_row = s_tdata[59:54];

    assign col_clamp = (in_col > CIDX_W'(GRID_COLS - 1)) ? CIDX_W'(GRID_COLS - 1) : in_col;
    assign row_clamp = (in_row > CIDX_W'(GRID_ROWS - 1)) ? CIDX_W'(GRID_ROWS - 1) : in_row;

    // Region test on 25-bit signed values; the far edges are exact.
    logic signed [DIFF_W-1:0] x_lo;
    logic signed [DIFF_W-1:0] y_lo;
    logic signed [DIFF_W-1:0] x_hi;
    logic signed [DIFF_W-1:0] y_hi;
    logic signed [DIFF_W-1:0] cx_w;
    logic signed [DIFF_W-1:0] cy_w;
    logic                     outside;

    assign x_lo = {region_x_reg[COORD_W-1], region_x_reg};
    assign y_lo = {region_y_reg[COORD_W-1], region_y_reg};
    assign x_hi = x_lo + $signed({2'b00, region_width_reg});
    assign y_hi = y_lo + $signed({2'b00, region_height_reg});
    assign cx_w = {cx_reg[COORD_W-1], cx_reg};
    assign cy_w = {cy_reg[COORD_W-1], cy_reg};
    assign outside = (cx_w < x_lo) || (cy_w < y_lo) || (cx_w > x_hi) || (cy_w > y_hi);

    // Neighbourhood bounds, clamped to the grid.
    logic [COL_W:0] col_plus2;
    logic [ROW_W:0] row_plus2;

    assign col_plus2 = {1'b0, col_reg} + (COL_W + 1)'(2);
    assign row_plus2 = {1'b0, row_reg} + (ROW_W + 1)'(2);

    // Coordinate differences to the stored point read back.
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;

    assign sx = store_rdata[COORD_W-1:0];
    assign sy = store_rdata[POINT_W-1:COORD_W];
    assign dx = cx_w - {sx[COORD_W-1], sx};
    assign dy = cy_w - {sy[COORD_W-1], sy};

    // Shared squaring unit: radius once per word, then dx and dy per point.
    logic [DIFF_W-1:0] mul_a;
    logic [SQ_W:0]     dist2;
    logic              too_close;
    logic              slot_ok;
    logic              last_col;
    logic              last_cell;

    always_comb
    begin
        case (state_reg)
            S_REGION: mul_a = {2'b00, min_radius_reg};
            S_SQY:    mul_a = ady_reg;
            default:  mul_a = adx_reg;
        endcase
    end

    assign prod_next = mul_a * mul_a;
    assign dist2     = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign too_close = dist2 < {1'b0, limit_reg};

    assign slot_ok     = (grid_rdata != '0) && (grid_rdata <= SLOT_W'(MAX_POINTS));
    assign store_raddr = PADDR_W'(grid_rdata - SLOT_W'(1));
    assign last_col    = (ic_reg == c1_reg);
    assign last_cell   = last_col && (ir_reg == r1_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        r1_next        = r1_reg;
        ic_next        = ic_reg;
        ir_next        = ir_reg;
        adx_next       = adx_reg;
        ady_next       = ady_reg;
        acc_next       = acc_reg;
        limit_next     = limit_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        grid_we        = 1'b0;
        grid_waddr     = cell_addr(row_reg, col_reg);
        grid_wdata     = total_reg + SLOT_W'(1);
        store_we       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = clr_reg;
                grid_wdata = '0;
                clr_next   = clr_reg + CELL_W'(1);
                if (clr_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cx_next    = in_x;
                    cy_next    = in_y;
                    col_next   = col_clamp[COL_W-1:0];
                    row_next   = row_clamp[ROW_W-1:0];
                    state_next = S_REGION;
                end
            end
            S_REGION:
            begin
                // The squarer works on the radius in this cycle.
                slot_next = '0;
                c0_next   = (col_reg >= COL_W'(2)) ? col_reg - COL_W'(2) : '0;
                c1_next   = (col_plus2 > (COL_W + 1)'(GRID_COLS - 1)) ?
                            COL_W'(GRID_COLS - 1) : col_plus2[COL_W-1:0];
                r1_next   = (row_plus2 > (ROW_W + 1)'(GRID_ROWS - 1)) ?
                            ROW_W'(GRID_ROWS - 1) : row_plus2[ROW_W-1:0];
                ic_next   = (col_reg >= COL_W'(2)) ? col_reg - COL_W'(2) : '0;
                ir_next   = (row_reg >= ROW_W'(2)) ? row_reg - ROW_W'(2) : '0;
                if (outside)
                begin
                    verdict_next = VERDICT_OUTSIDE;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                limit_next = prod_reg;
                state_next = S_GRID;
            end
            S_GRID:
            begin
                // Grid address of the visited cell is on the read port.
                state_next = S_ENT;
            end
            S_ENT:
            begin
                if (slot_ok)
                begin
                    state_next = S_PT;
                end
                else if (last_cell)
                begin
                    state_next = S_CAP;
                end
                else
                begin
                    ic_next    = last_col ? c0_reg : ic_reg + COL_W'(1);
                    ir_next    = last_col ? ir_reg + ROW_W'(1) : ir_reg;
                    state_next = S_GRID;
                end
            end
            S_PT:
            begin
                adx_next   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                ady_next   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                state_next = S_SQX;
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                acc_next   = prod_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (too_close)
                begin
                    verdict_next = VERDICT_TOO_CLOSE;
                    state_next   = S_DONE;
                end
                else if (last_cell)
                begin
                    state_next = S_CAP;
                end
                else
                begin
                    ic_next    = last_col ? c0_reg : ic_reg + COL_W'(1);
                    ir_next    = last_col ? ir_reg + ROW_W'(1) : ir_reg;
                    state_next = S_GRID;
                end
            end
            S_CAP:
            begin
                if (total_reg >= SLOT_W'(MAX_POINTS))
                begin
                    verdict_next = VERDICT_FULL;
                end
                else
                begin
                    // Append the point and mark its cell with the one-based slot.
                    store_we     = 1'b1;
                    grid_we      = 1'b1;
                    total_next   = total_reg + SLOT_W'(1);
                    slot_next    = total_reg + SLOT_W'(1);
                    verdict_next = VERDICT_ACCEPT;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {total_reg, slot_reg, verdict_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            c0_reg        <= '0;
            c1_reg        <= '0;
            r1_reg        <= '0;
            ic_reg        <= '0;
            ir_reg        <= '0;
            adx_reg       <= '0;
            ady_reg       <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            limit_reg     <= '0;
            slot_reg      <= '0;
            verdict_reg   <= VERDICT_ACCEPT;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            c0_reg        <= c0_next;
            c1_reg        <= c1_next;
            r1_reg        <= r1_next;
            ic_reg        <= ic_next;
            ir_reg        <= ir_next;
            adx_reg       <= adx_next;
            ady_reg       <= ady_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            limit_reg     <= limit_next;
            slot_reg      <= slot_next;
            verdict_reg   <= verdict_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // The store never holds more points than it has slots.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= SLOT_W'(MAX_POINTS))
        else $error("point count exceeds store capacity");

    // The point count only moves as a point is appended.
    a_total_moves_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> ($past(state_reg) == S_CAP))
        else $error("point count changed outside an append");

    // An accepted result names the newest slot; a rejected one names none.
    a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == VERDICT_ACCEPT)) |->
        (m_tdata[12:2] == m_tdata[23:13]) && (m_tdata[12:2] != '0))
        else $error("accepted result with wrong slot");

    a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != VERDICT_ACCEPT)) |-> (m_tdata[12:2] == '0))
        else $error("rejected result carries a slot");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### rtl/pdc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(DEPTH)-1:0]        waddr,
    input  wire logic [WIDTH-1:0]                wdata,
    input  wire logic [$clog2(DEPTH)-1:0]        raddr,
    output      logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### test/poisson_disc_candidate_check_unit_test.sv
// Self-checking testbench of the Poisson-disc candidate check unit: directed table,
// then random candidate streams and a store-filling run, checked word by word.
// Depends on pdc_pkg and the RTL of poisson_disc_candidate_check_unit only.
`timescale 1ns / 1ps

module poisson_disc_candidate_check_unit_test
    import pdc_pkg::*;
();

    // Cycles without any accepted word before the run is declared hung. The
    // slowest quiet stretch is the grid sweep after reset or the long receiver
    // hold-off below.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int RANDOM_ITEMS   = 800;
    localparam int DRAIN_CYCLES   = 200;

    // Expected contents of one result word.
    typedef struct packed {
        verdict_t            verdict;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   count;
    } outcome_t;

    // One row of the directed table. When typed is set, want is the expected
    // word as written; otherwise the word is predicted.
    typedef struct packed {
        logic [1:0]          setting;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [CIDX_W-1:0]   col;
        logic [CIDX_W-1:0]   row;
        bit                  typed;
        outcome_t            want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tdata from bit 0 up: cand_x[23:0], cand_y[23:0], cell_col[5:0],
    // cell_row[5:0], 4 zero bits.
    logic [63:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tdata from bit 0 up: verdict[1:0], stored_index[10:0], point_count[10:0].
    logic [23:0]            m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    poisson_disc_candidate_check_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the block's registers and memories, kept by the predictor.
    longint box_x, box_y, box_w, box_h, min_gap;
    longint pt_x [MAX_POINTS];
    longint pt_y [MAX_POINTS];
    int     cell_slot [CELLS];
    int     n_points;

    outcome_t outcomes_due [$];
    int       mismatches;
    int       quiet_cycles;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_req;

    // Directed register settings: everything at its reset value, a rectangle
    // spanning the whole negative quarter with a radius of one unit, and every
    // register at its maximum so that the far edges need the 25th bit.
    logic [23:0] directed_cfg [0:2][0:4] = '{
        '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h000100},
        '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}
    };

    directed_row_t directed_rows [0:20] = '{
        // Degenerate rectangle at the origin with zero radius: a point sitting
        // exactly on another one is not closer than zero, so both are taken.
        '{2'd0, 24'h000000, 24'h000000, 6'd0,  6'd0,  1'b1, '{VERDICT_ACCEPT, 11'd1, 11'd1}},
        '{2'd0, 24'h000000, 24'h000000, 6'd0,  6'd0,  1'b1, '{VERDICT_ACCEPT, 11'd2, 11'd2}},
        // One LSB off the single inside point on each side, then a far corner.
        '{2'd0, 24'h000001, 24'h000000, 6'd0,  6'd0,  1'b1, '{VERDICT_OUTSIDE, 11'd0, 11'd2}},
        '{2'd0, 24'hFFFFFF, 24'h000000, 6'd0,  6'd0,  1'b1, '{VERDICT_OUTSIDE, 11'd0, 11'd2}},
        '{2'd0, 24'h000000, 24'h000001, 6'd0,  6'd0,  1'b1, '{VERDICT_OUTSIDE, 11'd0, 11'd2}},
        '{2'd0, 24'h000000, 24'hFFFFFF, 6'd0,  6'd0,  1'b1, '{VERDICT_OUTSIDE, 11'd0, 11'd2}},
        '{2'd0, 24'h7FFFFF, 24'h800000, 6'd63, 6'd63, 1'b1, '{VERDICT_OUTSIDE, 11'd0, 11'd2}},
        // Both corners of the negative quarter are inside, edges included.
        '{2'd1, 24'h800000, 24'h800000, 6'd0,  6'd0,  1'b1, '{VERDICT_ACCEPT, 11'd3, 11'd3}},
        '{2'd1, 24'hFFFFFF, 24'hFFFFFF, 6'd63, 6'd63, 1'b1, '{VERDICT_ACCEPT, 11'd4, 11'd4}},
        '{2'd1, 24'h000000, 24'hFFFFFF, 6'd31, 6'd31, 1'b1, '{VERDICT_OUTSIDE, 11'd0, 11'd4}},
        // Too close to the corner point, then exactly one radius away.
        '{2'd1, 24'h800064, 24'h800000, 6'd0,  6'd0,  1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        '{2'd1, 24'h800100, 24'h800000, 6'd1,  6'd0,  1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        // Cell indices past the grid clamp onto the last cell.
        '{2'd1, 24'hFFFFFE, 24'hFFFFFF, 6'd32, 6'd40, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        // Cell not matching the coordinates is trusted, then found again.
        '{2'd1, 24'hFFFFFE, 24'hFFFFFE, 6'd10, 6'd10, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        '{2'd1, 24'hFFFFFD, 24'hFFFFFD, 6'd10, 6'd10, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        // Close to the corner but filed five columns away: not seen.
        '{2'd1, 24'h800080, 24'h800080, 6'd5,  6'd0,  1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        '{2'd1, 24'h800000, 24'hFFFFFF, 6'd0,  6'd31, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        // All registers at maximum: only the largest coordinate is inside.
        '{2'd2, 24'h7FFFFF, 24'h7FFFFF, 6'd31, 6'd31, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        '{2'd2, 24'h7FFFFF, 24'h7FFFFF, 6'd30, 6'd30, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        '{2'd2, 24'h7FFFFE, 24'h7FFFFF, 6'd31, 6'd31, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}},
        '{2'd2, 24'h800000, 24'h7FFFFF, 6'd31, 6'd31, 1'b0, '{VERDICT_ACCEPT, 11'd0, 11'd0}}
    };

    // Register settings used by the random part, one per 100 candidates:
    // 0 plain, 1 raw random words, 2 zero radius, 3 maximum radius,
    // 4 rectangle of zero width or height.
    int random_kinds [0:7] = '{0, 0, 3, 0, 1, 2, 0, 4};
    // Idle percentages per 200 candidates: none, sender mostly idle,
    // receiver mostly stalling, both at times.
    int send_idle_plan [0:3] = '{0, 88, 0, 36};
    int recv_stall_plan [0:3] = '{0, 0, 88, 36};

    // Works out the verdict for one candidate and updates the shadow state
    // exactly as the block does when the candidate is taken. Checks run in
    // order: rectangle, then the 5x5 neighbourhood, then store capacity.
    function automatic outcome_t judge_candidate(input logic [COORD_W-1:0] x_bits,
                                                 input logic [COORD_W-1:0] y_bits,
                                                 input logic [CIDX_W-1:0]  col_in,
                                                 input logic [CIDX_W-1:0]  row_in);
        outcome_t res;
        longint   cx, cy, dx, dy, reach;
        int       col, row, c0, c1, r0, r1, ent;
        bit       hit;
        cx = $signed(x_bits);
        cy = $signed(y_bits);
        col = (int'(col_in) > GRID_COLS - 1) ? GRID_COLS - 1 : int'(col_in);
        row = (int'(row_in) > GRID_ROWS - 1) ? GRID_ROWS - 1 : int'(row_in);
        hit = 1'b0;
        res.verdict = VERDICT_ACCEPT;
        res.slot = '0;
        if (cx < box_x || cy < box_y || cx > box_x + box_w || cy > box_y + box_h)
        begin
            res.verdict = VERDICT_OUTSIDE;
        end
        else
        begin
            reach = min_gap * min_gap;
            c0 = (col >= 2) ? col - 2 : 0;
            c1 = (col + 2 > GRID_COLS - 1) ? GRID_COLS - 1 : col + 2;
            r0 = (row >= 2) ? row - 2 : 0;
            r1 = (row + 2 > GRID_ROWS - 1) ? GRID_ROWS - 1 : row + 2;
            for (int r = r0; r <= r1; r++)
            begin
                for (int c = c0; c <= c1; c++)
                begin
                    ent = cell_slot[r * GRID_COLS + c];
                    if (ent != 0 && !hit)
                    begin
                        dx = cx - pt_x[ent - 1];
                        dy = cy - pt_y[ent - 1];
                        if (dx * dx + dy * dy < reach)
                            hit = 1'b1;
                    end
                end
            end
            if (hit)
                res.verdict = VERDICT_TOO_CLOSE;
            else if (n_points >= MAX_POINTS)
                res.verdict = VERDICT_FULL;
            else
            begin
                pt_x[n_points] = cx;
                pt_y[n_points] = cy;
                n_points++;
                res.slot = SLOT_W'(n_points);
                // An occupied cell simply takes the newest slot.
                cell_slot[row * GRID_COLS + col] = n_points;
            end
        end
        res.count = SLOT_W'(n_points);
        return res;
    endfunction

    // Grid index along one axis for an offset into the rectangle.
    function automatic logic [CIDX_W-1:0] cell_of(input longint ofs, input longint span,
                                                  input int cells);
        longint c;
        c = (span <= 0) ? 0 : (ofs * cells) / (span + 1);
        if (c < 0)
            c = 0;
        if (c > cells - 1)
            c = cells - 1;
        return CIDX_W'(c);
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_REGION_X:      box_x = $signed(value);
            CFG_REGION_Y:      box_y = $signed(value);
            CFG_REGION_WIDTH:  box_w = value[LEN_W-1:0];
            CFG_REGION_HEIGHT: box_h = value[LEN_W-1:0];
            CFG_MIN_RADIUS:    min_gap = value[LEN_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic apply_setting(input logic [23:0] rx, input logic [23:0] ry,
                                 input logic [23:0] rw, input logic [23:0] rh,
                                 input logic [23:0] rad);
        write_reg(CFG_REGION_X, rx);
        write_reg(CFG_REGION_Y, ry);
        write_reg(CFG_REGION_WIDTH, rw);
        write_reg(CFG_REGION_HEIGHT, rh);
        write_reg(CFG_MIN_RADIUS, rad);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stops offering words and waits until every expected result is back.
    // Each candidate yields exactly one result word, so the block is idle then.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    // Offers one candidate word, with random idle cycles in front of it. The
    // task returns at the rising edge that accepted the word, so the next call
    // (or drain_results) drives s_tvalid at the very next falling edge.
    task automatic offer_candidate(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   input logic [CIDX_W-1:0] col, input logic [CIDX_W-1:0] row,
                                   input bit typed, input outcome_t want);
        outcome_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, row, col, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = judge_candidate(x, y, col, row);
        if (typed)
            predicted = want;
        outcomes_due.insert(outcomes_due.size(), predicted);
    endtask

    task automatic random_setting(input int kind);
        logic [23:0] v [0:4];
        v[0] = 24'($urandom_range(0, 24'h3FFFFF)) - 24'h200000;
        v[1] = 24'($urandom_range(0, 24'h3FFFFF)) - 24'h200000;
        v[2] = 24'($urandom_range(4096, 262144));
        v[3] = 24'($urandom_range(4096, 262144));
        v[4] = v[2] / 24'($urandom_range(24, 64));
        case (kind)
            1:
            begin
                for (int k = 0; k < 5; k++)
                    v[k] = 24'($urandom);
            end
            2: v[4] = 24'h000000;
            3: v[4] = 24'h7FFFFF;
            4:
            begin
                if ($urandom_range(1) == 0)
                    v[2] = 24'h000000;
                else
                    v[3] = 24'h000000;
            end
            default: ;
        endcase
        apply_setting(v[0], v[1], v[2], v[3], v[4]);
    endtask

    // Mostly well-formed candidates: inside the rectangle with the matching
    // cell, or placed right around a stored point to provoke near misses.
    // The rest have a random cell or are plain noise.
    task automatic make_candidate(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y,
                                  output logic [CIDX_W-1:0] col, output logic [CIDX_W-1:0] row);
        int     pick, k;
        longint cx, cy, span;
        pick = $urandom_range(99);
        cx = box_x + longint'($urandom_range(32'(box_w)));
        cy = box_y + longint'($urandom_range(32'(box_h)));
        if (pick < 4)
            cx = ($urandom_range(1) == 0) ? box_x : box_x + box_w;
        else if (pick < 8)
            cy = ($urandom_range(1) == 0) ? box_y : box_y + box_h;
        else if (pick < 10)
            cx = box_x - 1;
        else if (pick >= 60 && pick < 80 && n_points > 0)
        begin
            k = $urandom_range(n_points - 1);
            span = min_gap + 1;
            cx = pt_x[k] + longint'($urandom_range(32'(2 * span))) - span;
            cy = pt_y[k] + longint'($urandom_range(32'(2 * span))) - span;
        end
        x = cx[COORD_W-1:0];
        y = cy[COORD_W-1:0];
        col = cell_of(cx - box_x, box_w, GRID_COLS);
        row = cell_of(cy - box_y, box_h, GRID_ROWS);
        if (pick >= 80 && pick < 90)
        begin
            col = CIDX_W'($urandom);
            row = CIDX_W'($urandom);
        end
        else if (pick >= 90)
        begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            col = CIDX_W'($urandom);
            row = CIDX_W'($urandom);
        end
    endtask

    // Receiver: random stalls, or one long hold-off when asked for. The hold
    // is counted here so the sender keeps offering words meanwhile, filling
    // the output register and the search stage until s_tready drops.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: every accepted result word is matched against the
    // oldest expectation, field by field.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result word %h arrived with nothing expected", m_tdata);
                mismatches++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (m_tdata[1:0] !== want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[12:2] !== want.slot)
                begin
                    $error("stored_index: expected %0d, got %0d", want.slot, m_tdata[12:2]);
                    mismatches++;
                end
                if (m_tdata[23:13] !== want.count)
                begin
                    $error("point_count: expected %0d, got %0d", want.count, m_tdata[23:13]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a run that accepts nothing on either side for too long hangs.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int                  cur;
        logic [COORD_W-1:0]  cx, cy;
        logic [CIDX_W-1:0]   cc, rr;
        int                  extra;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_REGION_X;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        box_x = 0;
        box_y = 0;
        box_w = 0;
        box_h = 0;
        min_gap = 0;
        n_points = 0;
        foreach (cell_slot[k])
            cell_slot[k] = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Register settings change only between groups of
        // rows, once every outstanding result is back. The block sweeps its
        // grid after reset; the first word simply waits for s_tready.
        cur = -1;
        foreach (directed_rows[i])
        begin
            if (int'(directed_rows[i].setting) != cur)
            begin
                cur = directed_rows[i].setting;
                drain_results();
                apply_setting(directed_cfg[cur][0], directed_cfg[cur][1], directed_cfg[cur][2],
                              directed_cfg[cur][3], directed_cfg[cur][4]);
            end
            offer_candidate(directed_rows[i].x, directed_rows[i].y, directed_rows[i].col,
                            directed_rows[i].row, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random candidates under a new register setting every 100 words and
        // a new idle pattern every 200.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                drain_results();
                random_setting(random_kinds[i / 100]);
                send_idle_pct = send_idle_plan[(i / 200) % 4];
                recv_stall_pct = recv_stall_plan[(i / 200) % 4];
            end
            // Long receiver hold-off while the sender keeps pushing.
            if (i == 40)
                hold_req = 1'b1;
            make_candidate(cx, cy, cc, rr);
            offer_candidate(cx, cy, cc, rr, 1'b0, '0);
        end

        // Fill the point store: zero radius over the negative quarter, so
        // every inside candidate is taken until the store is full.
        drain_results();
        apply_setting(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h000000);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        extra = 0;
        while (n_points < MAX_POINTS || extra < 6)
        begin
            if (n_points >= MAX_POINTS)
                extra++;
            cx = 24'h800000 + COORD_W'($urandom_range(24'h7FFFFF));
            cy = 24'h800000 + COORD_W'($urandom_range(24'h7FFFFF));
            offer_candidate(cx, cy, CIDX_W'($urandom), CIDX_W'($urandom), 1'b0, '0);
        end

        // With the store full, the rectangle and distance checks still come
        // first: maximum radius finds near points, and noise lands outside.
        drain_results();
        apply_setting(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        for (int i = 0; i < 12; i++)
        begin
            make_candidate(cx, cy, cc, rr);
            offer_candidate(cx, cy, cc, rr, 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
